// ===== rtl/spfq_pkg.sv =====
// Package for the strict priority four class queue.
// Holds sizes, codes, item structs and the command struct shared by all modules.
// No dependencies.
package spfq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int TICKET_BITS = 16;
  localparam int NCLASS = 4;
  localparam int CLS_W = $clog2(NCLASS);
  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int LEN_W = $clog2(QUEUE_DEPTH + 1);
  localparam int OCC_W = $clog2(NCLASS * QUEUE_DEPTH + 1);
  localparam int MEM_DEPTH = NCLASS << IDX_W;
  localparam int ADDR_W = CLS_W + IDX_W;
  localparam int TICKET_EXT = (TICKET_BITS > 16) ? TICKET_BITS : 16;
  localparam int MOD_W = 11;
  localparam int MINUTES_PER_HOUR = 60;
  localparam int PEAK_MAX = 511;
  localparam int CMD_FIFO_DEPTH = 2;
  localparam int CF_PTR_W = $clog2(CMD_FIFO_DEPTH);
  localparam int CF_CNT_W = $clog2(CMD_FIFO_DEPTH + 1);

  localparam logic [1:0] KIND_ARRIVE  = 2'd0;
  localparam logic [1:0] KIND_SERVE   = 2'd1;
  localparam logic [1:0] KIND_LENGTHS = 2'd2;
  localparam logic [1:0] KIND_REPORT  = 2'd3;

  localparam logic [2:0] ST_ACCEPTED = 3'd0;
  localparam logic [2:0] ST_DROPPED  = 3'd1;
  localparam logic [2:0] ST_SERVED   = 3'd2;
  localparam logic [2:0] ST_NONE     = 3'd3;
  localparam logic [2:0] ST_LENGTHS  = 3'd4;
  localparam logic [2:0] ST_REPORT   = 3'd5;

  typedef enum logic [2:0] {
    OP_ARRIVE,
    OP_DROP,
    OP_SERVE,
    OP_LENGTHS,
    OP_REPORT
  } op_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] ticket;
    logic [2:0]  class_code;
    logic [4:0]  hour;
    logic [5:0]  minute;
  } item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [15:0]        served_ticket;
    logic [1:0]         served_class;
    logic signed [11:0] wait_minutes;
    logic [15:0]        count_red;
    logic [15:0]        count_yellow;
    logic [15:0]        count_green;
    logic [15:0]        count_white;
    logic [15:0]        served_total;
    logic [8:0]         peak_occupancy;
    logic [10:0]        max_wait;
  } result_t;

  typedef struct packed {
    op_t                    op;
    logic [CLS_W-1:0]       cls;
    logic [TICKET_BITS-1:0] ticket;
    logic [MOD_W-1:0]       mod;
  } cmd_t;

  typedef struct packed {
    logic [TICKET_BITS-1:0] ticket;
    logic [MOD_W-1:0]       minute;
  } entry_t;

  typedef struct packed {
    logic serving;
    logic cmd_pop;
  } back_stat_t;

endpackage

// ===== rtl/spfq_front.sv =====
// Front end of the strict priority four class queue.
// Decodes an input item into a command and computes its minute of day; uses spfq_pkg.
module spfq_front (
  input  spfq_pkg::item_t request,
  input  logic            push,
  output logic            full,
  input  logic            fifo_full,
  output logic            cmd_push,
  output spfq_pkg::cmd_t  cmd
);
  import spfq_pkg::*;

  logic [TICKET_EXT-1:0] ticket_wide;

  assign full = fifo_full;
  assign cmd_push = push && !fifo_full;
  assign ticket_wide = TICKET_EXT'(request.ticket);

  always_comb begin
    cmd.cls = request.class_code[CLS_W-1:0];
    cmd.ticket = ticket_wide[TICKET_BITS-1:0];
    cmd.mod = MOD_W'(request.hour) * MOD_W'(MINUTES_PER_HOUR) + MOD_W'(request.minute);
    case (request.kind)
      KIND_ARRIVE: begin
        if (request.class_code[2]) begin
          cmd.op = OP_DROP;
        end else begin
          cmd.op = OP_ARRIVE;
        end
      end
      KIND_SERVE:   cmd.op = OP_SERVE;
      KIND_LENGTHS: cmd.op = OP_LENGTHS;
      KIND_REPORT:  cmd.op = OP_REPORT;
      default:      cmd.op = OP_REPORT;
    endcase
  end

endmodule

// ===== rtl/spfq_cmd_fifo.sv =====
// Short command queue between the front end and the back end.
// Holds decoded commands so either side can stall on its own; uses spfq_pkg.
module spfq_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  spfq_pkg::cmd_t wr_data,
  output logic           full,
  input  logic           pop,
  output spfq_pkg::cmd_t rd_data,
  output logic           empty
);
  import spfq_pkg::*;

  cmd_t                slots [CMD_FIFO_DEPTH];
  logic [CF_PTR_W-1:0] wptr;
  logic [CF_PTR_W-1:0] rptr;
  logic [CF_CNT_W-1:0] count;

  assign full = (count == CF_CNT_W'(CMD_FIFO_DEPTH));
  assign empty = (count == '0);
  assign rd_data = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == CF_PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == CF_PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/spfq_back.sv =====
// Back end of the strict priority four class queue.
// Keeps the class queues in one memory, runs commands and holds the result; uses spfq_pkg.
module spfq_back (
  input  logic                 clk,
  input  logic                 rst,
  input  spfq_pkg::cmd_t       cmd,
  input  logic                 cmd_empty,
  output logic                 cmd_pop,
  output spfq_pkg::result_t    result,
  output logic                 empty,
  input  logic                 pop,
  output spfq_pkg::back_stat_t stat
);
  import spfq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_SERVE = 2'b10
  } state_t;

  state_t           state;
  state_t           state_next;
  entry_t           mem [MEM_DEPTH];
  entry_t           rd_data;
  logic             mem_we;
  logic             mem_re;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  entry_t           wr_entry;

  logic [IDX_W-1:0] head [NCLASS];
  logic [IDX_W-1:0] head_next [NCLASS];
  logic [IDX_W-1:0] tail [NCLASS];
  logic [IDX_W-1:0] tail_next [NCLASS];
  logic [LEN_W-1:0] len [NCLASS];
  logic [LEN_W-1:0] len_next [NCLASS];
  logic [15:0]      served_pc [NCLASS];
  logic [15:0]      served_pc_next [NCLASS];
  logic [15:0]      served_count;
  logic [15:0]      served_count_next;
  logic [OCC_W-1:0] occ;
  logic [OCC_W-1:0] occ_next;
  logic [8:0]       peak;
  logic [8:0]       peak_next;
  logic [10:0]      longest;
  logic [10:0]      longest_next;
  logic [CLS_W-1:0] sel;
  logic [CLS_W-1:0] sel_next;
  logic [MOD_W-1:0] mod_hold;
  logic [MOD_W-1:0] mod_hold_next;
  logic             res_valid;
  logic             res_load;
  result_t          res_next;

  logic                  found;
  logic [CLS_W-1:0]      pick;
  logic [OCC_W-1:0]      occ_inc;
  logic [8:0]            occ_sat;
  logic signed [11:0]    wait_val;
  logic [TICKET_EXT-1:0] ticket_wide;

  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  assign empty = !res_valid;
  assign stat.serving = (state == S_SERVE);
  assign stat.cmd_pop = cmd_pop;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_entry;
    end
    if (mem_re) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_comb begin
    found = 1'b0;
    pick = '0;
    for (int c = NCLASS - 1; c >= 0; c--) begin
      if (len[c] != '0) begin
        found = 1'b1;
        pick = CLS_W'(c);
      end
    end
  end

  assign occ_inc = occ + 1'b1;
  assign occ_sat = (32'(occ_inc) > PEAK_MAX) ? 9'(PEAK_MAX) : 9'(occ_inc);
  assign wait_val = $signed({1'b0, mod_hold}) - $signed({1'b0, rd_data.minute});
  assign ticket_wide = TICKET_EXT'(rd_data.ticket);

  always_comb begin
    state_next = state;
    head_next = head;
    tail_next = tail;
    len_next = len;
    served_pc_next = served_pc;
    served_count_next = served_count;
    occ_next = occ;
    peak_next = peak;
    longest_next = longest;
    sel_next = sel;
    mod_hold_next = mod_hold;
    mem_we = 1'b0;
    mem_re = 1'b0;
    wr_addr = {cmd.cls, tail[cmd.cls]};
    wr_entry.ticket = cmd.ticket;
    wr_entry.minute = cmd.mod;
    rd_addr = {pick, head[pick]};
    cmd_pop = 1'b0;
    res_load = 1'b0;
    res_next = '0;
    case (state)
      S_IDLE: begin
        if (!cmd_empty && (!res_valid || pop)) begin
          cmd_pop = 1'b1;
          case (cmd.op)
            OP_ARRIVE: begin
              res_load = 1'b1;
              if (len[cmd.cls] == LEN_W'(QUEUE_DEPTH)) begin
                res_next.status = ST_DROPPED;
              end else begin
                res_next.status = ST_ACCEPTED;
                mem_we = 1'b1;
                tail_next[cmd.cls] = next_slot(tail[cmd.cls]);
                len_next[cmd.cls] = len[cmd.cls] + 1'b1;
                occ_next = occ_inc;
                if (occ_sat > peak) begin
                  peak_next = occ_sat;
                end
              end
            end
            OP_SERVE: begin
              if (found) begin
                mem_re = 1'b1;
                sel_next = pick;
                mod_hold_next = cmd.mod;
                state_next = S_SERVE;
              end else begin
                res_load = 1'b1;
                res_next.status = ST_NONE;
              end
            end
            OP_LENGTHS: begin
              res_load = 1'b1;
              res_next.status = ST_LENGTHS;
              res_next.count_red = 16'(len[0]);
              res_next.count_yellow = 16'(len[1]);
              res_next.count_green = 16'(len[2]);
              res_next.count_white = 16'(len[3]);
            end
            OP_REPORT: begin
              res_load = 1'b1;
              res_next.status = ST_REPORT;
              res_next.count_red = served_pc[0];
              res_next.count_yellow = served_pc[1];
              res_next.count_green = served_pc[2];
              res_next.count_white = served_pc[3];
            end
            default: begin
              res_load = 1'b1;
              res_next.status = ST_DROPPED;
            end
          endcase
        end
      end
      S_SERVE: begin
        res_load = 1'b1;
        state_next = S_IDLE;
        head_next[sel] = next_slot(head[sel]);
        len_next[sel] = len[sel] - 1'b1;
        occ_next = occ - 1'b1;
        served_pc_next[sel] = sat_inc(served_pc[sel]);
        served_count_next = sat_inc(served_count);
        if (wait_val > 0 && wait_val[10:0] > longest) begin
          longest_next = wait_val[10:0];
        end
        res_next.status = ST_SERVED;
        res_next.served_ticket = ticket_wide[15:0];
        res_next.served_class = 2'(sel);
        res_next.wait_minutes = wait_val;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    res_next.served_total = served_count_next;
    res_next.peak_occupancy = peak_next;
    res_next.max_wait = longest_next;
  end

  always_ff @(posedge clk) begin
    sel <= sel_next;
    mod_hold <= mod_hold_next;
    if (res_load) begin
      result <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res_valid <= 1'b0;
      served_count <= '0;
      occ <= '0;
      peak <= '0;
      longest <= '0;
      for (int c = 0; c < NCLASS; c++) begin
        head[c] <= '0;
        tail[c] <= '0;
        len[c] <= '0;
        served_pc[c] <= '0;
      end
    end else begin
      state <= state_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (pop) begin
        res_valid <= 1'b0;
      end
      served_count <= served_count_next;
      occ <= occ_next;
      peak <= peak_next;
      longest <= longest_next;
      head <= head_next;
      tail <= tail_next;
      len <= len_next;
      served_pc <= served_pc_next;
    end
  end

endmodule

// ===== rtl/strict_priority_four_class_queue.sv =====
// Top level of the strict priority four class queue.
// Connects spfq_front, spfq_cmd_fifo and spfq_back; uses spfq_pkg.
//
// Items enter through a two-entry command queue and give exactly one result each,
// held in an output register until popped. Arrivals, drops and queries are handled in
// the back end's idle state; a serve also passes the serve state, because the head
// entry is read from a synchronous memory. A result is registered after its item
// passes the command queue. No clearing pass is needed after reset.
module strict_priority_four_class_queue (
  input  logic              clk,
  input  logic              rst,
  input  spfq_pkg::item_t   request,
  input  logic              push,
  output logic              full,
  output spfq_pkg::result_t result,
  output logic              empty,
  input  logic              pop
);
  import spfq_pkg::*;

  cmd_t       front_cmd;
  logic       front_push;
  logic       fifo_full;
  cmd_t       fifo_cmd;
  logic       fifo_empty;
  logic       back_pop;
  back_stat_t stat;

  spfq_front u_front (
    .request   (request),
    .push      (push),
    .full      (full),
    .fifo_full (fifo_full),
    .cmd_push  (front_push),
    .cmd       (front_cmd)
  );

  spfq_cmd_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (front_push),
    .wr_data (front_cmd),
    .full    (fifo_full),
    .pop     (back_pop),
    .rd_data (fifo_cmd),
    .empty   (fifo_empty)
  );

  spfq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (fifo_cmd),
    .cmd_empty (fifo_empty),
    .cmd_pop   (back_pop),
    .result    (result),
    .empty     (empty),
    .pop       (pop),
    .stat      (stat)
  );

`ifndef SYNTH
  a_push_fills: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |=> !fifo_empty)
    else $error("accepted item did not reach the command queue");

  a_serve_blocks: assert property (@(posedge clk) disable iff (rst)
    stat.serving |-> !stat.cmd_pop)
    else $error("command taken while a serve is in progress");

  a_serve_len: assert property (@(posedge clk) disable iff (rst)
    stat.cmd_pop |-> (empty || pop))
    else $error("command taken while the result register is occupied");

  a_served_total: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.status == ST_SERVED) |-> (result.served_total != 16'd0))
    else $error("served item with a zero total");
`endif

endmodule
